// ===== design/ofdc_pkg.sv =====
// ----------------------------------------------------------------------------
// ofdc_pkg
// Shared types and constants for the object filter / dedup counter.
// ----------------------------------------------------------------------------
package ofdc_pkg;

  // operand of the shared compare unit, wide enough for every value and limit
  localparam int unsigned OPND_W    = 18;
  localparam int unsigned FIELD_W   = 12;
  localparam int unsigned AGE_W     = 16;
  localparam int unsigned IN_ID_W   = 16;
  localparam int unsigned LIM_W     = 16;
  localparam int unsigned TOTAL_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 64;

  typedef logic signed [OPND_W-1:0] opnd_t;

  typedef enum logic [1:0] {
    CMP_GE,
    CMP_LE,
    CMP_GT,
    CMP_LT
  } cmp_op_e;

  // lim_mode: operand b is a limit (-1 disables, other negatives always fail)
  typedef struct packed {
    cmp_op_e op;
    logic    lim_mode;
  } cmp_ctl_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_LIMITS  = 3'd0,
    CFG_HEIGHT_LIMITS = 3'd1,
    CFG_X_LIMITS      = 3'd2,
    CFG_Y_LIMITS      = 3'd3,
    CFG_MOTION_LIMITS = 3'd4,
    CFG_COUNT_BOX     = 3'd5
  } cfg_idx_e;

endpackage

// ===== design/ofdc_cmp.sv =====
// ----------------------------------------------------------------------------
// ofdc_cmp
// Shared signed compare unit, with optional limit semantics on operand b.
// ----------------------------------------------------------------------------
module ofdc_cmp
  import ofdc_pkg::*;
(
  input  opnd_t    a_i,
  input  opnd_t    b_i,
  input  cmp_ctl_t ctl_i,
  output logic     pass_o
);

  logic raw;

  always_comb begin
    case (ctl_i.op)
      CMP_GE:  raw = (a_i >= b_i);
      CMP_LE:  raw = (a_i <= b_i);
      CMP_GT:  raw = (a_i > b_i);
      CMP_LT:  raw = (a_i < b_i);
      default: raw = 1'b0;
    endcase
  end

  always_comb begin
    pass_o = raw;
    if (ctl_i.lim_mode) begin
      if (b_i == opnd_t'(-1)) begin
        pass_o = 1'b1;
      end else if (b_i < 0) begin
        pass_o = 1'b0;
      end
    end
  end

endmodule

// ===== design/ofdc_ring.sv =====
// ----------------------------------------------------------------------------
// ofdc_ring
// Ring of recently counted ids: one registered read, one write per cycle,
// valid bits cleared at reset, match against the current id.
// ----------------------------------------------------------------------------
module ofdc_ring
  import ofdc_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned KEY_W = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             hit_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  logic [KEY_W-1:0] wr_key_i
);

  logic [KEY_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [KEY_W-1:0] rd_key_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_key_i;
    end
    if (rd_en_i) begin
      rd_key_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign hit_o = rd_vld_q && (rd_key_q == key_i);

endmodule

// ===== design/object_filter_dedup_counter_core.sv =====
// ----------------------------------------------------------------------------
// object_filter_dedup_counter_core
// Filters tracked objects by id history, limits and a counting box, and keeps
// left-to-right and right-to-left totals.
// ----------------------------------------------------------------------------
// Usage:
//   input channel: one tracked object per word, taken when in_valid_i is high
//   and in_stall_o is low. in_stall_o stays high while a word is being worked.
//   output channel: one result word per input word (counted flag plus both
//   totals), taken when out_valid_o is high and out_stall_i is low.
//   config channel: cfg_valid_i/cfg_ready_o, register index and data; write
//   only while the block is idle. Unknown indexes are dropped.
// Flow: the id ring is scanned one entry per cycle through its registered
//   read port, then up to 14 limit and box checks run one per cycle through
//   the shared compare unit, then an update step that waits for the output
//   register to be free. A duplicate id skips the checks and a failing check
//   ends them early. The next word is taken the cycle after the result is
//   loaded.
// Stall: the finished result waits in the output register; a new word can be
//   accepted meanwhile, but its update waits until the register is free.
// Reset: all limits disabled, counting box zero, ring valid bits, slot
//   pointer and totals cleared.
// ----------------------------------------------------------------------------
module object_filter_dedup_counter_core
  import ofdc_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 16,
  parameter int unsigned ID_BITS    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [IN_ID_W-1:0]   object_id_i,
  input  logic [AGE_W-1:0]     age_frames_i,
  input  logic [FIELD_W-1:0]   point_x_i,
  input  logic [FIELD_W-1:0]   point_y_i,
  input  logic [FIELD_W-1:0]   start_x_i,
  input  logic [FIELD_W-1:0]   box_left_i,
  input  logic [FIELD_W-1:0]   box_top_i,
  input  logic [FIELD_W-1:0]   box_width_i,
  input  logic [FIELD_W-1:0]   box_height_i,
  input  logic                 moving_right_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 counted_o,
  output logic [TOTAL_W-1:0]   rightward_total_o,
  output logic [TOTAL_W-1:0]   leftward_total_o,

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int unsigned KEY_W = (ID_BITS < IN_ID_W) ? ID_BITS : IN_ID_W;
  localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_UPDATE
  } state_e;

  typedef enum logic [3:0] {
    STEP_AGE      = 4'd0,
    STEP_TRAVEL   = 4'd1,
    STEP_W_MIN    = 4'd2,
    STEP_H_MIN    = 4'd3,
    STEP_W_MAX    = 4'd4,
    STEP_H_MAX    = 4'd5,
    STEP_X_MIN    = 4'd6,
    STEP_Y_MIN    = 4'd7,
    STEP_X_MAX    = 4'd8,
    STEP_Y_MAX    = 4'd9,
    STEP_BOX_L    = 4'd10,
    STEP_BOX_R    = 4'd11,
    STEP_BOX_T    = 4'd12,
    STEP_BOX_B    = 4'd13
  } step_e;

  // configuration
  logic [31:0]          width_lim_q, height_lim_q, x_lim_q, y_lim_q, motion_lim_q;
  logic [CFG_DAT_W-1:0] count_box_q;

  // held input word
  logic [KEY_W-1:0]   id_q;
  logic [AGE_W-1:0]   age_q;
  logic [FIELD_W-1:0] px_q, py_q, sx_q, bl_q, bt_q, bw_q, bh_q;
  logic               right_q;

  // control
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               rd_chk_q, rd_chk_d;
  logic               dup_q, dup_d;
  step_e              step_q, step_d;
  logic               pass_q, pass_d;
  logic [IDX_W-1:0]   wr_slot_q, wr_slot_d;
  logic [TOTAL_W-1:0] rcnt_q, rcnt_d, lcnt_q, lcnt_d;
  logic               out_vld_q, out_vld_d;
  logic               out_cnt_q, out_cnt_d;

  logic     in_fire, upd_fire;
  logic     ring_rd_en, ring_wr_en, ring_hit;
  opnd_t    cmp_a, cmp_b;
  cmp_ctl_t cmp_ctl;
  logic     cmp_pass;

  logic [FIELD_W-1:0] travel;
  logic [FIELD_W:0]   right_edge, bottom_edge;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o       = out_vld_q;
  assign counted_o         = out_cnt_q;
  assign rightward_total_o = rcnt_q;
  assign leftward_total_o  = lcnt_q;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_lim_q  <= '1;
      height_lim_q <= '1;
      x_lim_q      <= '1;
      y_lim_q      <= '1;
      motion_lim_q <= '1;
      count_box_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH_LIMITS:  width_lim_q  <= cfg_data_i[31:0];
        CFG_HEIGHT_LIMITS: height_lim_q <= cfg_data_i[31:0];
        CFG_X_LIMITS:      x_lim_q      <= cfg_data_i[31:0];
        CFG_Y_LIMITS:      y_lim_q      <= cfg_data_i[31:0];
        CFG_MOTION_LIMITS: motion_lim_q <= cfg_data_i[31:0];
        CFG_COUNT_BOX:     count_box_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input word capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      id_q    <= object_id_i[KEY_W-1:0];
      age_q   <= age_frames_i;
      px_q    <= point_x_i;
      py_q    <= point_y_i;
      sx_q    <= start_x_i;
      bl_q    <= box_left_i;
      bt_q    <= box_top_i;
      bw_q    <= box_width_i;
      bh_q    <= box_height_i;
      right_q <= moving_right_i;
    end
  end

  ofdc_ring #(
    .DEPTH (RING_DEPTH),
    .KEY_W (KEY_W),
    .IDX_W (IDX_W)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (ring_rd_en),
    .rd_addr_i (cnt_q[IDX_W-1:0]),
    .key_i     (id_q),
    .hit_o     (ring_hit),
    .wr_en_i   (ring_wr_en),
    .wr_addr_i (wr_slot_q),
    .wr_key_i  (id_q)
  );

  function automatic opnd_t lim_half(input logic [LIM_W-1:0] h);
    return opnd_t'(signed'(h));
  endfunction

  function automatic opnd_t uval(input logic [LIM_W-1:0] v);
    return opnd_t'({2'b00, v});
  endfunction

  assign travel      = (px_q >= sx_q) ? (px_q - sx_q) : (sx_q - px_q);
  assign right_edge  = {1'b0, bl_q} + {1'b0, bw_q};
  assign bottom_edge = {1'b0, bt_q} + {1'b0, bh_q};

  // operand select for the current check
  always_comb begin
    cmp_a   = '0;
    cmp_b   = '0;
    cmp_ctl = '{op: CMP_GE, lim_mode: 1'b1};
    unique case (step_q)
      STEP_AGE: begin
        cmp_a   = uval(age_q);
        cmp_b   = lim_half(motion_lim_q[15:0]);
        cmp_ctl = '{op: CMP_GT, lim_mode: 1'b1};
      end
      STEP_TRAVEL: begin
        cmp_a = uval(LIM_W'(travel));
        cmp_b = lim_half(motion_lim_q[31:16]);
      end
      STEP_W_MIN: begin
        cmp_a = uval(LIM_W'(bw_q));
        cmp_b = lim_half(width_lim_q[15:0]);
      end
      STEP_H_MIN: begin
        cmp_a = uval(LIM_W'(bh_q));
        cmp_b = lim_half(height_lim_q[15:0]);
      end
      STEP_W_MAX: begin
        cmp_a   = uval(LIM_W'(bw_q));
        cmp_b   = lim_half(width_lim_q[31:16]);
        cmp_ctl = '{op: CMP_LE, lim_mode: 1'b1};
      end
      STEP_H_MAX: begin
        cmp_a   = uval(LIM_W'(bh_q));
        cmp_b   = lim_half(height_lim_q[31:16]);
        cmp_ctl = '{op: CMP_LE, lim_mode: 1'b1};
      end
      STEP_X_MIN: begin
        cmp_a = uval(LIM_W'(bl_q));
        cmp_b = lim_half(x_lim_q[15:0]);
      end
      STEP_Y_MIN: begin
        cmp_a = uval(LIM_W'(bt_q));
        cmp_b = lim_half(y_lim_q[15:0]);
      end
      STEP_X_MAX: begin
        cmp_a   = uval(LIM_W'(right_edge));
        cmp_b   = lim_half(x_lim_q[31:16]);
        cmp_ctl = '{op: CMP_LE, lim_mode: 1'b1};
      end
      STEP_Y_MAX: begin
        cmp_a   = uval(LIM_W'(bottom_edge));
        cmp_b   = lim_half(y_lim_q[31:16]);
        cmp_ctl = '{op: CMP_LE, lim_mode: 1'b1};
      end
      STEP_BOX_L: begin
        cmp_a   = uval(LIM_W'(px_q));
        cmp_b   = uval(count_box_q[15:0]);
        cmp_ctl = '{op: CMP_GT, lim_mode: 1'b0};
      end
      STEP_BOX_R: begin
        cmp_a   = uval(LIM_W'(px_q));
        cmp_b   = uval(count_box_q[47:32]);
        cmp_ctl = '{op: CMP_LT, lim_mode: 1'b0};
      end
      STEP_BOX_T: begin
        cmp_a   = uval(LIM_W'(py_q));
        cmp_b   = uval(count_box_q[31:16]);
        cmp_ctl = '{op: CMP_GT, lim_mode: 1'b0};
      end
      STEP_BOX_B: begin
        cmp_a   = uval(LIM_W'(py_q));
        cmp_b   = uval(count_box_q[63:48]);
        cmp_ctl = '{op: CMP_LT, lim_mode: 1'b0};
      end
      default: ;
    endcase
  end

  ofdc_cmp u_cmp (
    .a_i    (cmp_a),
    .b_i    (cmp_b),
    .ctl_i  (cmp_ctl),
    .pass_o (cmp_pass)
  );

  assign upd_fire = (state_q == ST_UPDATE) && (!out_vld_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rd_chk_d   = 1'b0;
    dup_d      = dup_q;
    step_d     = step_q;
    pass_d     = pass_q;
    wr_slot_d  = wr_slot_q;
    rcnt_d     = rcnt_q;
    lcnt_d     = lcnt_q;
    out_vld_d  = out_vld_q;
    out_cnt_d  = out_cnt_q;
    ring_rd_en = 1'b0;
    ring_wr_en = 1'b0;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
          dup_d   = 1'b0;
        end
      end
      ST_SCAN: begin
        // read data arrives in the cycle after its address
        if (rd_chk_q && ring_hit) begin
          dup_d = 1'b1;
        end
        if (cnt_q < CNT_W'(RING_DEPTH)) begin
          ring_rd_en = 1'b1;
          rd_chk_d   = 1'b1;
          cnt_d      = cnt_q + 1'b1;
        end else if (dup_q || (rd_chk_q && ring_hit)) begin
          pass_d  = 1'b0;
          state_d = ST_UPDATE;
        end else begin
          pass_d  = 1'b1;
          step_d  = STEP_AGE;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!cmp_pass) begin
          pass_d  = 1'b0;
          state_d = ST_UPDATE;
        end else if (step_q == STEP_BOX_B) begin
          state_d = ST_UPDATE;
        end else begin
          step_d = step_e'(step_q + 1'b1);
        end
      end
      ST_UPDATE: begin
        if (upd_fire) begin
          out_vld_d = 1'b1;
          out_cnt_d = pass_q;
          if (pass_q) begin
            ring_wr_en = 1'b1;
            if (right_q) begin
              rcnt_d = rcnt_q + 1'b1;
            end else begin
              lcnt_d = lcnt_q + 1'b1;
            end
            wr_slot_d = (wr_slot_q == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_slot_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rd_chk_q  <= 1'b0;
      dup_q     <= 1'b0;
      step_q    <= STEP_AGE;
      pass_q    <= 1'b0;
      wr_slot_q <= '0;
      rcnt_q    <= '0;
      lcnt_q    <= '0;
      out_vld_q <= 1'b0;
      out_cnt_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_chk_q  <= rd_chk_d;
      dup_q     <= dup_d;
      step_q    <= step_d;
      pass_q    <= pass_d;
      wr_slot_q <= wr_slot_d;
      rcnt_q    <= rcnt_d;
      lcnt_q    <= lcnt_d;
      out_vld_q <= out_vld_d;
      out_cnt_q <= out_cnt_d;
    end
  end

  // the last ring entry must still be checked when the scan ends
  a_scan_end_checked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cnt_q == CNT_W'(RING_DEPTH)) |-> rd_chk_q)
    else $error("scan ended without checking the last ring entry");

  // a rejected object leaves both totals untouched
  a_reject_keeps_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && !pass_q) |=> ($stable(rcnt_q) && $stable(lcnt_q)))
    else $error("total changed for an object that was not counted");

  // a counted object moves exactly one total (the ring slot advance is not checked here)
  a_count_moves_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && pass_q) |=> ((rcnt_q != $past(rcnt_q)) != (lcnt_q != $past(lcnt_q))))
    else $error("counted object did not advance exactly one total");

  // a pending result is never overwritten by the next update
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> (out_vld_q && $stable(out_cnt_q)))
    else $error("stalled result lost or overwritten");

endmodule
